[hdl/pcwch_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pcwch_pkg
// shared constants, types and helpers for the canvas writer with color
// histogram: grid geometry, color bins, result codes and control structs
// ----------------------------------------------------------------------------
package pcwch_pkg;

    localparam int GRID_WIDTH  = 96;
    localparam int GRID_HEIGHT = 96;
    localparam int CELL_TOTAL  = GRID_WIDTH * GRID_HEIGHT;

    localparam int ADDR_W = (CELL_TOTAL > 1) ? $clog2(CELL_TOTAL) : 1;
    localparam int XW     = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
    localparam int YW     = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
    localparam int CNT_W  = $clog2(CELL_TOTAL + 1);

    localparam int SEQ_W     = 32;
    localparam int COORD_W   = 16;
    localparam int COLOR_W   = 8;
    localparam int OUT_CNT_W = 14;
    localparam int NUM_BINS  = 7;

    localparam int IN_W  = 72;
    localparam int OUT_W = 136;

    localparam logic [COLOR_W-1:0] RGB_RED    = 8'hE0;
    localparam logic [COLOR_W-1:0] RGB_GREEN  = 8'h1C;
    localparam logic [COLOR_W-1:0] RGB_BLUE   = 8'h03;
    localparam logic [COLOR_W-1:0] RGB_YELLOW = 8'hFC;
    localparam logic [COLOR_W-1:0] RGB_BLACK  = 8'h00;
    localparam logic [COLOR_W-1:0] RGB_WHITE  = 8'hFF;

    typedef enum logic [2:0] {
        BIN_RED    = 3'd0,
        BIN_GREEN  = 3'd1,
        BIN_BLUE   = 3'd2,
        BIN_YELLOW = 3'd3,
        BIN_BLACK  = 3'd4,
        BIN_WHITE  = 3'd5,
        BIN_OTHER  = 3'd6
    } t_bin;

    typedef enum logic [1:0] {
        STAT_OK  = 2'd0,
        STAT_BAD = 2'd1,
        STAT_DUP = 2'd2
    } t_status;

    typedef enum logic {
        REQ_DRAW  = 1'b0,
        REQ_FRAME = 1'b1
    } t_req;

    typedef struct packed {
        logic clr_we;
        logic rd;
        logic upd;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
    } t_sts;

    function automatic t_bin bin_of(input logic [COLOR_W-1:0] c);
        t_bin b;
        unique case (c)
            RGB_RED:    b = BIN_RED;
            RGB_GREEN:  b = BIN_GREEN;
            RGB_BLUE:   b = BIN_BLUE;
            RGB_YELLOW: b = BIN_YELLOW;
            RGB_BLACK:  b = BIN_BLACK;
            RGB_WHITE:  b = BIN_WHITE;
            default:    b = BIN_OTHER;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

[hdl/pcwch_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pcwch_ctrl
// sequencer: clearing pass after reset, then read / update per item,
// holds the result valid flag
// ----------------------------------------------------------------------------
module pcwch_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_tvalid,
    output logic                 o_s_tready,
    output logic                 o_m_tvalid,
    input  wire logic            i_m_tready,
    output pcwch_pkg::t_cmd      o_cmd,
    input  wire pcwch_pkg::t_sts i_sts
);
    import pcwch_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_UPD
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;
    logic   accept;

    assign out_free     = !r_out_valid || i_m_tready;
    assign o_s_tready   = (r_state == S_IDLE);
    assign accept       = i_s_tvalid && o_s_tready;
    assign o_m_tvalid   = r_out_valid;
    assign o_cmd.clr_we = (r_state == S_CLEAR);
    assign o_cmd.rd     = accept;
    assign o_cmd.upd    = (r_state == S_UPD) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    if (i_sts.clr_done) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_CLEAR;
            endcase
            if (o_cmd.upd) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_accept_to_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_UPD))
        else $error("accepted item not followed by update");

    a_clear_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> (r_state == S_CLEAR))
        else $error("clearing pass not started after reset");

    a_upd_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.upd |=> r_out_valid)
        else $error("update without result");

endmodule
`default_nettype wire

[hdl/pcwch_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pcwch_dp
// datapath: cell memory with clearing pass, color counts, sequence and
// frame tracking, result register
// ----------------------------------------------------------------------------
module pcwch_dp (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire pcwch_pkg::t_cmd           i_cmd,
    output pcwch_pkg::t_sts                o_sts,
    input  wire logic [pcwch_pkg::IN_W-1:0] i_s_tdata,
    input  wire logic                      i_s_tuser,
    input  wire logic                      i_s_tlast,
    output logic [pcwch_pkg::OUT_W-1:0]    o_m_tdata
);
    import pcwch_pkg::*;

    logic [COLOR_W-1:0] mem [CELL_TOTAL];

    logic [ADDR_W-1:0]  r_clr_addr;
    logic [COLOR_W-1:0] r_rd_data;
    logic               r_req;
    logic [SEQ_W-1:0]   r_seq;
    logic               r_inside;
    logic [ADDR_W-1:0]  r_addr;
    logic [COLOR_W-1:0] r_color;
    logic               r_last;
    logic [SEQ_W-1:0]   r_last_draw_seq;
    logic [SEQ_W-1:0]   r_last_frame_seq;
    logic               r_dirty;
    logic [CNT_W-1:0]   r_cnt [NUM_BINS];
    logic [OUT_W-1:0]   r_out;

    logic [CNT_W-1:0]   n_cnt [NUM_BINS];
    logic [COORD_W-1:0] in_x;
    logic [COORD_W-1:0] in_y;
    logic               in_inside;
    logic [ADDR_W-1:0]  in_addr;
    logic               dup;
    logic               wr_cell;
    logic               frame_end;
    logic               changed;
    logic               clear_ev;
    t_bin               old_bin;
    t_bin               new_bin;
    t_status            status;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [COLOR_W-1:0] mem_wdata;

    assign in_x      = i_s_tdata[47:32];
    assign in_y      = i_s_tdata[63:48];
    assign in_inside = (in_x < COORD_W'(GRID_WIDTH)) && (in_y < COORD_W'(GRID_HEIGHT));
    assign in_addr   = ADDR_W'(ADDR_W'(in_y[YW-1:0]) * ADDR_W'(GRID_WIDTH))
                     + ADDR_W'(in_x[XW-1:0]);

    assign o_sts.clr_done = (r_clr_addr == ADDR_W'(CELL_TOTAL - 1));

    assign dup       = (r_req == REQ_FRAME) ? (r_seq == r_last_frame_seq)
                                            : (r_seq == r_last_draw_seq);
    assign wr_cell   = !dup && r_inside && (r_rd_data != r_color);
    assign old_bin   = bin_of(r_rd_data);
    assign new_bin   = bin_of(r_color);
    assign frame_end = (r_req == REQ_FRAME) && !dup && r_last;
    assign changed   = (r_req == REQ_FRAME) ? (frame_end && (r_dirty || wr_cell)) : wr_cell;
    assign clear_ev  = (r_req == REQ_FRAME) && changed
                     && (n_cnt[BIN_BLACK] == CNT_W'(CELL_TOTAL));

    always_comb begin
        if (dup) begin
            status = STAT_DUP;
        end else if (!r_inside) begin
            status = STAT_BAD;
        end else begin
            status = STAT_OK;
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_BINS; i++) begin
            n_cnt[i] = r_cnt[i];
            if (wr_cell && (old_bin == t_bin'(i)) && (n_cnt[i] != '0)) begin
                n_cnt[i] = n_cnt[i] - 1'b1;
            end
            if (wr_cell && (new_bin == t_bin'(i))) begin
                n_cnt[i] = n_cnt[i] + 1'b1;
            end
        end
    end

    assign mem_we    = i_cmd.clr_we || (i_cmd.upd && wr_cell);
    assign mem_waddr = i_cmd.clr_we ? r_clr_addr : r_addr;
    assign mem_wdata = i_cmd.clr_we ? RGB_BLACK : r_color;

    // cell memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.rd) begin
            r_rd_data <= mem[in_addr];
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_req    <= i_s_tuser;
            r_seq    <= i_s_tdata[31:0];
            r_inside <= in_inside;
            r_addr   <= in_addr;
            r_color  <= i_s_tdata[71:64];
            r_last   <= i_s_tlast;
        end
        if (i_cmd.upd) begin
            r_out <= {2'b00, clear_ev, changed,
                      OUT_CNT_W'(n_cnt[BIN_OTHER]), OUT_CNT_W'(n_cnt[BIN_WHITE]),
                      OUT_CNT_W'(n_cnt[BIN_BLACK]), OUT_CNT_W'(n_cnt[BIN_YELLOW]),
                      OUT_CNT_W'(n_cnt[BIN_BLUE]), OUT_CNT_W'(n_cnt[BIN_GREEN]),
                      OUT_CNT_W'(n_cnt[BIN_RED]), r_seq, status};
        end
    end

    // counts and sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr       <= '0;
            r_last_draw_seq  <= '0;
            r_last_frame_seq <= '0;
            r_dirty          <= 1'b0;
            for (int i = 0; i < NUM_BINS; i++) begin
                r_cnt[i] <= (i == int'(BIN_BLACK)) ? CNT_W'(CELL_TOTAL) : '0;
            end
        end else begin
            if (i_cmd.clr_we && !o_sts.clr_done) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.upd) begin
                for (int i = 0; i < NUM_BINS; i++) begin
                    r_cnt[i] <= n_cnt[i];
                end
                if (!dup) begin
                    if (r_req == REQ_DRAW) begin
                        r_last_draw_seq <= r_seq;
                    end else if (r_last) begin
                        r_last_frame_seq <= r_seq;
                        r_dirty          <= 1'b0;
                    end else begin
                        r_dirty <= r_dirty || wr_cell;
                    end
                end
            end
        end
    end

    assign o_m_tdata = r_out;

    a_no_write_on_dup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.upd && dup) |-> !mem_we)
        else $error("duplicate item wrote the grid");

    a_clear_needs_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.upd && clear_ev) |-> (changed && frame_end))
        else $error("clear event outside a changed frame end");

    a_dirty_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.upd && frame_end) |=> !r_dirty)
        else $error("frame state not cleared at frame end");

endmodule
`default_nettype wire

[hdl/pixel_canvas_writer_color_histogram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_canvas_writer_color_histogram
// 96x96 rgb332 canvas with seven running color counts, single cell draws
// and streamed background frames, one result item per input item
// ----------------------------------------------------------------------------
// an accepted item reads its cell; in the update state the cell is written,
// the result is registered and valid rises; a new item is taken only after
// the previous one is updated; stalls while the previous result is not taken
// reset: synchronous; then a clearing pass over all 9216 cells (one cell a cycle)
// writes the grid black, tready stays low until it ends
module pixel_canvas_writer_color_histogram (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_s_tvalid,
    output logic                             o_s_tready,
    // seq[31:0], cell_x[47:32], cell_y[63:48], color[71:64]
    input  wire logic [pcwch_pkg::IN_W-1:0]  i_s_tdata,
    // req_type
    input  wire logic                        i_s_tuser,
    input  wire logic                        i_s_tlast,
    output logic                             o_m_tvalid,
    input  wire logic                        i_m_tready,
    // status[1:0], ack_seq[33:2], red[47:34], green[61:48], blue[75:62],
    // yellow[89:76], black[103:90], white[117:104], other[131:118],
    // counts_changed[132], clear_event[133], zero fill[135:134]
    output logic [pcwch_pkg::OUT_W-1:0]      o_m_tdata
);
    import pcwch_pkg::*;

    t_cmd cmd;
    t_sts sts;

    pcwch_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    pcwch_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .i_s_tlast (i_s_tlast),
        .o_m_tdata (o_m_tdata)
    );

endmodule
`default_nettype wire
